FILE: rtl/mbrb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the row blitter.
`timescale 1ns / 1ps
`default_nettype none
package mbrb_pkg;

    localparam int ROW_WORDS   = 20;
    localparam int SCREEN_ROWS = 400;
    localparam int FRAME_DEPTH = ROW_WORDS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        REQ_OR   = 2'd0,
        REQ_AND  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NOP  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        SZ_8  = 2'd0,
        SZ_16 = 2'd1,
        SZ_32 = 2'd2
    } size_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic phase1;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } ctrl_status_t;

endpackage
`default_nettype wire

FILE: rtl/mbrb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_array[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/mbrb_ctrl.sv
// Controller state machine: clearing pass, accept, read-modify-write phases and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_ctrl
    import mbrb_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ACC   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.phase1 = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // The second word is written only when the result can be loaded.
                if (!m_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/mbrb_dp.sv
// Datapath: address and pattern alignment, frame buffer RAM, merge logic and result registers.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_dp
    import mbrb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [9:0]  s_pix_x,
    input  wire logic [8:0]  s_pix_y,
    input  wire logic [31:0] s_pattern,
    input  wire logic [1:0]  s_pattern_size,
    input  wire ctrl_cmd_t   cmd,
    output ctrl_status_t     status,
    output logic [31:0]      m_read_word,
    output logic             m_clipped
);

    logic [4:0]        word_idx;
    logic [4:0]        bit_off;
    logic              row_ok;
    logic              w0_ok;
    logic              w1_ok;
    logic              wr_req;
    logic [ADDR_W-1:0] addr0;
    logic [31:0]       data_al;
    logic [31:0]       cover_al;
    logic [63:0]       data_sh;
    logic [63:0]       cover_sh;
    logic              clip_in;

    req_t              req_reg;
    logic [ADDR_W-1:0] addr0_reg;
    logic              w0_ok_reg;
    logic              w1_ok_reg;
    logic [31:0]       d0_reg, d1_reg, c0_reg, c1_reg;
    logic              clip_reg;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]       m_read_word_reg;
    logic              m_clipped_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic              is_write;
    logic              is_or;
    logic [31:0]       merge0, merge1;

    assign word_idx = s_pix_x[9:5];
    assign bit_off  = s_pix_x[4:0];
    assign row_ok   = (32'(s_pix_y) < 32'(SCREEN_ROWS));
    assign w0_ok    = row_ok && (32'(word_idx) < 32'(ROW_WORDS));
    assign w1_ok    = row_ok && (32'(word_idx) + 32'd1 < 32'(ROW_WORDS));
    assign addr0    = ADDR_W'(32'(s_pix_y) * 32'(ROW_WORDS) + 32'(word_idx));
    assign wr_req   = (s_req_type == REQ_OR) || (s_req_type == REQ_AND);

    // Move the used pattern bits to the top of the word; the cover marks them.
    always_comb begin
        case (s_pattern_size)
            SZ_8: begin
                data_al  = {s_pattern[7:0], 24'd0};
                cover_al = {8'hFF, 24'd0};
            end
            SZ_16: begin
                data_al  = {s_pattern[15:0], 16'd0};
                cover_al = {16'hFFFF, 16'd0};
            end
            default: begin
                data_al  = s_pattern;
                cover_al = 32'hFFFF_FFFF;
            end
        endcase
    end

    assign data_sh  = {data_al, 32'd0} >> bit_off;
    assign cover_sh = {cover_al, 32'd0} >> bit_off;
    assign clip_in  = wr_req && (!row_ok || (!w0_ok && (|cover_sh[63:32]))
                                         || (!w1_ok && (|cover_sh[31:0])));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= req_t'(s_req_type);
            addr0_reg <= addr0;
            w0_ok_reg <= w0_ok;
            w1_ok_reg <= w1_ok;
            d0_reg    <= data_sh[63:32];
            d1_reg    <= data_sh[31:0];
            c0_reg    <= cover_sh[63:32];
            c1_reg    <= cover_sh[31:0];
            clip_reg  <= clip_in;
        end
    end

    assign is_write = (req_reg == REQ_OR) || (req_reg == REQ_AND);
    assign is_or    = (req_reg == REQ_OR);
    assign merge0   = is_or ? (ram_rdata | d0_reg) : (ram_rdata & (d0_reg | ~c0_reg));
    assign merge1   = is_or ? (ram_rdata | d1_reg) : (ram_rdata & (d1_reg | ~c1_reg));

    // The first word is read at accept, the second while the first is written back.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = addr0;
        if (cmd.accept) begin
            ram_re    = w0_ok && (s_req_type != REQ_NOP);
            ram_raddr = addr0;
        end else if (cmd.phase1) begin
            ram_re    = is_write && w1_ok_reg;
            ram_raddr = addr0_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.phase1) begin
            ram_we    = is_write && w0_ok_reg;
            ram_waddr = addr0_reg;
            ram_wdata = merge0;
        end else if (cmd.finish) begin
            ram_we    = is_write && w1_ok_reg;
            ram_waddr = addr0_reg + ADDR_W'(1);
            ram_wdata = merge1;
        end
    end

    mbrb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clr_cnt_next    = cmd.clr_step ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;
    assign status.clr_last = (clr_cnt_reg == ADDR_W'(FRAME_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Read data still holds the first word in the finishing cycle for a read request.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_read_word_reg <= ((req_reg == REQ_READ) && w0_ok_reg) ? ram_rdata : 32'd0;
            m_clipped_reg   <= clip_reg;
        end
    end

    assign m_read_word = m_read_word_reg;
    assign m_clipped   = m_clipped_reg;

endmodule
`default_nettype wire

FILE: rtl/mono_bitmap_row_blitter.sv
// Sequence: an accepted input beat moves the controller through ST_ACC and ST_FIN, and m_valid
// is registered when ST_FIN finishes; ST_FIN waits while an earlier result is not taken.
// The block works on one item at a time and takes no new beat before the last is finished, as
// the read-modify-write of up to two frame words goes through one RAM read and one write port.
// The result register frees the input side while a finished result waits to be taken.
// Reset: synchronous active-low aresetn; afterwards a clearing pass writes all 8000
// frame words to zero, with s_ready low until it completes.
`timescale 1ns / 1ps
`default_nettype none
module mono_bitmap_row_blitter
    import mbrb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [9:0]  s_pix_x,
    input  wire logic [8:0]  s_pix_y,
    input  wire logic [31:0] s_pattern,
    input  wire logic [1:0]  s_pattern_size,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_word,
    output logic             m_clipped
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    mbrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mbrb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_pix_x        (s_pix_x),
        .s_pix_y        (s_pix_y),
        .s_pattern      (s_pattern),
        .s_pattern_size (s_pattern_size),
        .cmd            (cmd),
        .status         (status),
        .m_read_word    (m_read_word),
        .m_clipped      (m_clipped)
    );

    // Only one item is in flight, so an accepted beat closes the input side at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is still in flight");

    // A fresh result must match an earlier accepted input beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result beat without matching accepted input beat");

    // A result never carries both read data and a clip flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> m_read_word == 32'd0)
        else $error("clipped result carries read data");

endmodule
`default_nettype wire
